[hw/rtl/writeback_data_cache_plru_top_assert.svh]
// Assertion macros shared by the checker of the data cache.
`ifndef WRITEBACK_DATA_CACHE_PLRU_TOP_ASSERT_SVH
`define WRITEBACK_DATA_CACHE_PLRU_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define WDC_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wdc check failed");

// Next-cycle implication, disabled during reset
`define WDC_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wdc check failed");

`endif

[hw/rtl/wdc_pkg.sv]
// ----------------------------------------------------------------------------
// wdc_pkg
// Types, opcodes and line helpers for the write-back data cache.
// ----------------------------------------------------------------------------
`default_nettype none

package wdc_pkg;

    localparam int WAYS     = 4;
    localparam int LINE_W   = 128;

    // Request opcodes
    localparam logic [1:0] OP_IDLE  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_STORE = 2'd2;
    localparam logic [1:0] OP_FILL  = 2'd3;

    // Access size codes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;

    // Tree bits: root selects pair, low bits select way inside pair
    localparam logic [2:0] TREE_ROOT = 3'h4;
    localparam logic [2:0] TREE_LEFT = 3'h2;
    localparam logic [2:0] TREE_RGHT = 3'h1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] address;
        logic [1:0]  size_code;
        logic        is_signed;
        logic [31:0] store_value;
        logic [5:0]  rob_tag;
        logic [3:0]  mem_index;
        logic [63:0] fill_low;
        logic [63:0] fill_high;
    } req_t;

    typedef struct packed {
        logic        load_valid;
        logic [31:0] load_value;
        logic [5:0]  load_tag;
        logic [3:0]  load_slot;
        logic        read_req_valid;
        logic [31:0] read_req_addr;
        logic        write_req_valid;
        logic [31:0] write_req_addr;
        logic [63:0] wb_low;
        logic [63:0] wb_high;
        logic        busy_res;
    } res_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic capture;
        logic lookup;
        logic execute;
        logic fill;
        logic nop;
        logic waiting;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic miss;
    } sts_t;

    // Mark a way most recently used
    function automatic logic [2:0] tree_touch(logic [2:0] p, logic [1:0] way);
        logic [2:0] q;
        q = p;
        if (way[1] == 1'b0) q = q | TREE_ROOT;
        else                q = q & ~TREE_ROOT;
        case (way)
            2'd0:    q = q | TREE_LEFT;
            2'd1:    q = q & ~TREE_LEFT;
            2'd2:    q = q | TREE_RGHT;
            default: q = q & ~TREE_RGHT;
        endcase
        return q;
    endfunction

    // Way the tree points at
    function automatic logic [1:0] tree_victim(logic [2:0] p);
        logic [1:0] w;
        if ((p & TREE_ROOT) != 3'd0) w = ((p & TREE_RGHT) != 3'd0) ? 2'd3 : 2'd2;
        else                         w = ((p & TREE_LEFT) != 3'd0) ? 2'd1 : 2'd0;
        return w;
    endfunction

    // Bytes of an access: one, two or four
    function automatic logic [3:0] size_mask(logic [1:0] sz);
        logic [3:0] m;
        case (sz)
            SZ_BYTE: m = 4'h1;
            SZ_HALF: m = 4'h3;
            default: m = 4'hF;
        endcase
        return m;
    endfunction

    // Read up to four bytes, offset wraps within the line, then extend
    function automatic logic [31:0] line_read(logic [LINE_W-1:0] line, logic [3:0] off,
                                              logic [1:0] sz, logic sgn);
        logic [31:0] v;
        logic [3:0]  idx;
        for (int i = 0; i < 4; i++) begin
            idx = off + 4'(i);
            v[8*i +: 8] = line[{idx, 3'b000} +: 8];
        end
        case (sz)
            SZ_BYTE: v = {{24{sgn & v[7]}}, v[7:0]};
            SZ_HALF: v = {{16{sgn & v[15]}}, v[15:0]};
            default: v = v;
        endcase
        return v;
    endfunction

    // Merge enabled store bytes into a line
    function automatic logic [LINE_W-1:0] line_merge(logic [LINE_W-1:0] line,
                                                     logic [3:0] off, logic [31:0] val,
                                                     logic [3:0] en);
        logic [LINE_W-1:0] l;
        logic [3:0]        idx;
        l = line;
        for (int i = 0; i < 4; i++) begin
            idx = off + 4'(i);
            if (en[i]) l[{idx, 3'b000} +: 8] = val[8*i +: 8];
        end
        return l;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/wdc_ctrl.sv]
// ----------------------------------------------------------------------------
// wdc_ctrl
// Sequencer for the data cache: clear pass, lookup, execute, fill, miss flag.
// ----------------------------------------------------------------------------
`default_nettype none

module wdc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [1:0]    opcode,
    output logic               busy,
    output wdc_pkg::cmd_t      cmd,
    input  wire wdc_pkg::sts_t sts
);
    import wdc_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_LOOK = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;
    localparam logic [2:0] S_FILL = 3'd5;
    localparam logic [2:0] S_NOP  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       waiting_reg, waiting_next;
    logic       accept;
    logic       is_access;

    assign accept    = start && (state_reg == S_IDLE);
    assign is_access = (opcode == OP_LOAD) || (opcode == OP_STORE);
    assign busy      = (state_reg != S_IDLE);

    // Next state and miss flag
    always_comb
    begin
        state_next   = state_reg;
        waiting_next = waiting_reg;
        case (state_reg)
            S_CLR:
            begin
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept) begin
                    if (!waiting_reg && is_access)           state_next = S_RD;
                    else if (waiting_reg && opcode == OP_FILL) state_next = S_RD;
                    else                                     state_next = S_NOP;
                end
            end
            S_RD:
            begin
                state_next = waiting_reg ? S_FILL : S_LOOK;
            end
            S_LOOK:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                waiting_next = sts.miss;
                state_next   = S_IDLE;
            end
            S_FILL:
            begin
                waiting_next = 1'b0;
                state_next   = S_IDLE;
            end
            S_NOP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd.clear   = (state_reg == S_CLR);
        cmd.capture = accept;
        cmd.lookup  = (state_reg == S_LOOK);
        cmd.execute = (state_reg == S_EXEC);
        cmd.fill    = (state_reg == S_FILL);
        cmd.nop     = (state_reg == S_NOP);
        cmd.waiting = waiting_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= S_CLR;
            waiting_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            waiting_reg <= waiting_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/wdc_dp.sv]
// ----------------------------------------------------------------------------
// wdc_dp
// Cache datapath: tag, tree and line memories, hit logic, parked miss, result.
// ----------------------------------------------------------------------------
`default_nettype none

module wdc_dp #(
    parameter int          SET_COUNT = 16,
    parameter logic [32:0] MEM_BYTES = 33'd1048576
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire wdc_pkg::req_t req,
    input  wire wdc_pkg::cmd_t cmd,
    output wdc_pkg::sts_t      sts,
    output logic               done,
    output wdc_pkg::res_t      res
);
    import wdc_pkg::*;

    localparam int IDX_W = $clog2(SET_COUNT);
    localparam int TAG_W = 28 - IDX_W;
    localparam int MW    = TAG_W + 2;     // {valid, dirty, tag}
    localparam int DA_W  = IDX_W + 2;

    // Storage
    logic [MW-1:0]     meta_mem [SET_COUNT][WAYS];
    logic [2:0]        tree_mem [SET_COUNT];
    logic [LINE_W-1:0] data_mem [SET_COUNT*WAYS];

    logic [MW-1:0]     meta_q [WAYS];
    logic [2:0]        tree_q;
    logic [LINE_W-1:0] data_q;

    req_t              req_reg;
    logic              hit_reg;
    logic [1:0]        way_reg;
    logic [MW-1:0]     vic_reg;
    logic [IDX_W-1:0]  clr_reg;

    // Parked miss
    logic              p_store_reg;
    logic [31:0]       p_addr_reg;
    logic [1:0]        p_size_reg;
    logic              p_sgn_reg;
    logic [31:0]       p_val_reg;
    logic [5:0]        p_tag_reg;
    logic [3:0]        p_slot_reg;
    logic [1:0]        p_way_reg;

    res_t              res_reg, res_next;
    logic              done_reg;

    logic [IDX_W-1:0]  req_set, p_set, rd_set;
    logic [TAG_W-1:0]  req_tag, p_tag;
    logic [3:0]        hit_vec;
    logic              hit_c;
    logic [1:0]        hit_way, sel_way;
    logic              any_inv;
    logic [1:0]        inv_way;
    logic [31:0]       st_addr;
    logic [3:0]        st_en;
    logic [LINE_W-1:0] fill_line;

    assign req_set   = req_reg.address[4 +: IDX_W] & IDX_W'(SET_COUNT - 1);
    assign p_set     = p_addr_reg[4 +: IDX_W] & IDX_W'(SET_COUNT - 1);
    assign req_tag   = req_reg.address[31 -: TAG_W];
    assign p_tag     = p_addr_reg[31 -: TAG_W];
    assign rd_set    = cmd.waiting ? p_set : req_set;
    assign fill_line = {req_reg.fill_high, req_reg.fill_low};

    // Tag compare, last match wins; victim is lowest invalid else tree
    always_comb
    begin
        hit_way = 2'd0;
        inv_way = 2'd0;
        any_inv = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w] = meta_q[w][MW-1] && (meta_q[w][TAG_W-1:0] == req_tag);
            if (hit_vec[w]) hit_way = 2'(w);
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!meta_q[w][MW-1]) begin
                any_inv = 1'b1;
                inv_way = 2'(w);
            end
        end
        hit_c   = (hit_vec != 4'd0);
        sel_way = hit_c ? hit_way : (any_inv ? inv_way : tree_victim(tree_q));
    end

    // Store byte enables, bytes at or past the memory end are dropped
    always_comb
    begin
        st_addr = cmd.fill ? p_addr_reg : req_reg.address;
        for (int i = 0; i < 4; i++) begin
            st_en[i] = ({2'b00, st_addr} + 34'(i)) < {1'b0, MEM_BYTES};
        end
        st_en = st_en & size_mask(cmd.fill ? p_size_reg : req_reg.size_code);
    end

    // Memories: registered reads, lane writes
    always_ff @(posedge clk)
    begin
        for (int w = 0; w < WAYS; w++) begin
            meta_q[w] <= meta_mem[rd_set][w];
        end
        tree_q <= tree_mem[rd_set];
        data_q <= data_mem[DA_W'({req_set, sel_way})];

        if (cmd.clear) begin
            for (int w = 0; w < WAYS; w++) begin
                meta_mem[clr_reg][w] <= '0;
            end
            tree_mem[clr_reg] <= 3'd0;
        end
        if (cmd.execute && hit_reg) begin
            tree_mem[req_set] <= tree_touch(tree_q, way_reg);
            if (req_reg.opcode == OP_STORE) begin
                meta_mem[req_set][way_reg] <= {2'b11, req_tag};
                data_mem[DA_W'({req_set, way_reg})] <=
                    line_merge(data_q, req_reg.address[3:0], req_reg.store_value, st_en);
            end
        end
        if (cmd.fill) begin
            tree_mem[p_set]            <= tree_touch(tree_q, p_way_reg);
            meta_mem[p_set][p_way_reg] <= {1'b1, p_store_reg, p_tag};
            data_mem[DA_W'({p_set, p_way_reg})] <= p_store_reg ?
                line_merge(fill_line, p_addr_reg[3:0], p_val_reg, st_en) : fill_line;
        end
    end

    // Request capture, lookup result, parked miss
    always_ff @(posedge clk)
    begin
        if (cmd.capture) req_reg <= req;
        if (cmd.lookup) begin
            hit_reg <= hit_c;
            way_reg <= sel_way;
            vic_reg <= meta_q[sel_way];
        end
        if (cmd.execute && !hit_reg) begin
            p_store_reg <= (req_reg.opcode == OP_STORE);
            p_addr_reg  <= req_reg.address;
            p_size_reg  <= req_reg.size_code;
            p_sgn_reg   <= req_reg.is_signed;
            p_val_reg   <= req_reg.store_value;
            p_tag_reg   <= req_reg.rob_tag;
            p_slot_reg  <= req_reg.mem_index;
            p_way_reg   <= way_reg;
        end
    end

    // Result word
    always_comb
    begin
        res_next = '0;
        if (cmd.execute) begin
            if (hit_reg) begin
                if (req_reg.opcode == OP_LOAD) begin
                    res_next.load_valid = 1'b1;
                    res_next.load_value = line_read(data_q, req_reg.address[3:0],
                                                    req_reg.size_code, req_reg.is_signed);
                    res_next.load_tag   = req_reg.rob_tag;
                    res_next.load_slot  = req_reg.mem_index;
                end
            end else begin
                res_next.read_req_valid = 1'b1;
                res_next.read_req_addr  = {req_reg.address[31:4], 4'h0};
                res_next.busy_res       = 1'b1;
                if (vic_reg[MW-2]) begin
                    res_next.write_req_valid = 1'b1;
                    res_next.write_req_addr  = {vic_reg[TAG_W-1:0], req_set, 4'h0};
                    res_next.wb_low          = data_q[63:0];
                    res_next.wb_high         = data_q[127:64];
                end
            end
        end else if (cmd.fill) begin
            if (!p_store_reg) begin
                res_next.load_valid = 1'b1;
                res_next.load_value = line_read(fill_line, p_addr_reg[3:0],
                                                p_size_reg, p_sgn_reg);
                res_next.load_tag   = p_tag_reg;
                res_next.load_slot  = p_slot_reg;
            end
        end else begin
            res_next.busy_res = cmd.waiting;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute || cmd.fill || cmd.nop) res_reg <= res_next;
    end

    // Strobe and clear sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
            clr_reg  <= '0;
        end else begin
            done_reg <= cmd.execute || cmd.fill || cmd.nop;
            if (cmd.clear) clr_reg <= clr_reg + 1'b1;
        end
    end

    assign sts.clr_last = (clr_reg == IDX_W'(SET_COUNT - 1));
    assign sts.miss     = !hit_reg;
    assign done         = done_reg;
    assign res          = res_reg;

endmodule

`default_nettype wire

[hw/rtl/writeback_data_cache_plru_top.sv]
// ----------------------------------------------------------------------------
// writeback_data_cache_plru_top
// 4-way write-back data cache, 16-byte lines, tree PLRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req and raise start; the word is taken on a clock
//   edge where start is high and busy is low. Loads and stores go in while no
//   miss is parked; a fill word (opcode 3) answers a parked miss. Other words
//   are taken and answered with a result that carries at most busy_res.
//   Result channel: one result word per request, shown on res for a single
//   cycle while done is high. The receiver cannot stall it.
//   Sequence: loads and stores pass the tag memory read, line memory read and
//   result register in series; a fill passes the tag memory read and result
//   register, an ignored word only the result register. A new word is taken
//   the cycle done rises; none is taken while an earlier one is in flight.
//   A miss reports read (and dirty writeback) requests and sets busy_res;
//   the fill word installs the line and serves the parked load or store.
//   Reset: a clearing pass writes every set's tags and tree bits with busy
//   high; nothing is accepted before it ends.
// ----------------------------------------------------------------------------
`default_nettype none

module writeback_data_cache_plru_top #(
    parameter int          SET_COUNT = 16,
    parameter logic [32:0] MEM_BYTES = 33'd1048576
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire wdc_pkg::req_t req,
    output logic               done,
    output wdc_pkg::res_t      res
);
    import wdc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    wdc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (req.opcode),
        .busy   (busy),
        .cmd    (cmd),
        .sts    (sts)
    );

    // Datapath
    wdc_dp #(
        .SET_COUNT (SET_COUNT),
        .MEM_BYTES (MEM_BYTES)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .done  (done),
        .res   (res)
    );

endmodule

`default_nettype wire

[hw/rtl/wdc_chk.sv]
// ----------------------------------------------------------------------------
// wdc_chk
// Port-level checks for the data cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "writeback_data_cache_plru_top_assert.svh"

module wdc_chk (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          done,
    input wire wdc_pkg::res_t res
);
    import wdc_pkg::*;

    // An accepted word always keeps the block busy next cycle
    `WDC_AST_NXT(a_accept_busy, start && !busy, busy)
    // A load answer never comes with a miss
    `WDC_AST_IMP(a_load_no_miss, done && res.load_valid, !res.read_req_valid)
    // Writeback only alongside a line read
    `WDC_AST_IMP(a_wb_with_read, done && res.write_req_valid, res.read_req_valid)
    // A miss always leaves the block waiting
    `WDC_AST_IMP(a_miss_busy, done && res.read_req_valid, res.busy_res)

endmodule

bind writeback_data_cache_plru_top wdc_chk u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .res   (res)
);

`default_nettype wire
